### sv/comment_line_classifier_assert.svh
// Assertion macros for the comment line classifier.
`ifndef COMMENT_LINE_CLASSIFIER_ASSERT_SVH
`define COMMENT_LINE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("comment_line_classifier: assertion failed");
// Check a property on every clock edge, reset included.
`define CLC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("comment_line_classifier: assertion failed");
`else
`define CLC_ASSERT(lbl, prop)
`define CLC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### sv/ccl_pkg.sv
// Types, constants and helper functions shared by the comment line classifier.
package ccl_pkg;

  localparam int BYTE_W = 8;
  localparam int TOK_W  = 64;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = 3;

  typedef enum logic [2:0] {
    CLS_BLANK        = 3'd0,
    CLS_SOURCE       = 3'd1,
    CLS_SINGLE       = 3'd2,
    CLS_BLOCK_INSIDE = 3'd3,
    CLS_BLOCK_END    = 3'd4,
    CLS_BLOCK_START  = 3'd5
  } class_t;

  typedef enum logic [2:0] {
    REG_SINGLE_TOKEN = 3'd0,
    REG_SINGLE_LEN   = 3'd1,
    REG_START_TOKEN  = 3'd2,
    REG_START_LEN    = 3'd3,
    REG_END_TOKEN    = 3'd4,
    REG_END_LEN      = 3'd5
  } cfg_reg_t;

  // Per-cycle control handed to the cells and the prefix units.
  typedef struct packed {
    logic shift;
    logic clear;
  } ctl_t;

  typedef struct packed {
    class_t cls;
    logic   in_block;
  } res_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  // Clamp a length register to the window depth.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] lim);
    return (len > lim) ? lim : len;
  endfunction

  function automatic logic [BYTE_W-1:0] tok_byte(input logic [TOK_W-1:0] tok,
                                                 input logic [IDX_W-1:0] idx);
    return tok[BYTE_W*idx +: BYTE_W];
  endfunction

endpackage

### sv/comment_line_classifier.sv
// Top level of the comment line classifier: control, cell row and result buffer.
//
// Text arrives one byte per transfer on the item channel; a transfer with
// line_end set closes the line and produces exactly one result (line_class,
// in_block), registered, on the result channel. Leading whitespace is skipped.
// The block takes one item every cycle while item_stall is low: each kept byte
// advances a row of TOKEN_BYTES window cells that compare the end token in the
// same cycle, while two prefix units check the single-line and block start
// tokens. Results pass through an output register backed by a one-entry skid
// buffer, so items keep flowing while a result waits; item_stall rises only
// when both entries are full. Configuration writes take effect at the next
// edge and must only be issued while the block is idle.
`include "comment_line_classifier_assert.svh"

module comment_line_classifier #(
  parameter int TOKEN_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  char_code,
  input  logic        line_end,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  line_class,
  output logic        in_block,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ccl_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH = LEN_W'(TOKEN_BYTES);

  // configuration registers
  logic [TOK_W-1:0] single_token;
  logic [LEN_W-1:0] single_len;
  logic [TOK_W-1:0] start_token;
  logic [LEN_W-1:0] start_len;
  logic [TOK_W-1:0] end_token;
  logic [LEN_W-1:0] end_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_token <= TOK_W'(12079);
      single_len   <= LEN_W'(2);
      start_token  <= TOK_W'(10799);
      start_len    <= LEN_W'(2);
      end_token    <= TOK_W'(12074);
      end_len      <= LEN_W'(2);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SINGLE_TOKEN: single_token <= cfg_data;
        REG_SINGLE_LEN:   single_len   <= cfg_data[LEN_W-1:0];
        REG_START_TOKEN:  start_token  <= cfg_data;
        REG_START_LEN:    start_len    <= cfg_data[LEN_W-1:0];
        REG_END_TOKEN:    end_token    <= cfg_data;
        REG_END_LEN:      end_len      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] sl;
  logic [LEN_W-1:0] bl;
  logic [LEN_W-1:0] el;

  assign sl = eff_len(single_len, DEPTH);
  assign bl = eff_len(start_len, DEPTH);
  assign el = eff_len(end_len, DEPTH);

  // input transfer and per-cycle control
  logic item_take;
  logic line_take;
  ctl_t ctl;

  logic             content_seen;
  logic [CNT_W-1:0] content_count;
  logic             end_seen;
  logic             block_open;
  logic             block_open_next;

  assign item_take = item_valid && !item_stall;
  assign line_take = item_take && line_end;

  // Drop leading whitespace; every byte from the first other one on is kept.
  assign ctl.shift = item_take && !line_end && (content_seen || !is_space(char_code));
  assign ctl.clear = line_take;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      content_seen  <= 1'b0;
      content_count <= '0;
    end else if (ctl.shift) begin
      content_seen <= 1'b1;
      if (content_count < CNT_W'(TOKEN_BYTES)) begin
        content_count <= content_count + CNT_W'(1);
      end
    end
  end

  // prefix units for the single-line and block start tokens
  logic single_hit;
  logic start_hit;

  ccl_prefix u_single (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .char_code (char_code),
    .count     (content_count),
    .len       (sl),
    .token     (single_token),
    .hit       (single_hit)
  );

  ccl_prefix u_start (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .char_code (char_code),
    .count     (content_count),
    .len       (bl),
    .token     (start_token),
    .hit       (start_hit)
  );

  // Row of window cells; cell 0 takes the newest byte, each hands on its own.
  logic [BYTE_W-1:0]      win_byte  [TOKEN_BYTES];
  logic [TOKEN_BYTES-1:0] win_valid;
  logic [TOKEN_BYTES-1:0] win_miss;

  for (genvar k = 0; k < TOKEN_BYTES; k++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    logic              valid_in;

    if (k == 0) begin : g_head
      assign byte_in  = char_code;
      assign valid_in = 1'b1;
    end else begin : g_link
      assign byte_in  = win_byte[k-1];
      assign valid_in = win_valid[k-1];
    end

    ccl_cell #(
      .TOKEN_BYTES (TOKEN_BYTES),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .byte_in    (byte_in),
      .valid_in   (valid_in),
      .end_len    (el),
      .end_token  (end_token),
      .held_byte  (win_byte[k]),
      .held_valid (win_valid[k]),
      .miss       (win_miss[k])
    );
  end

  // End token seen anywhere in the trimmed line; needs a full window of el bytes.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      end_seen <= 1'b0;
    end else if (ctl.shift && (el != '0) && !(|win_miss)) begin
      end_seen <= 1'b1;
    end
  end

  // line classification at the line end
  class_t line_cls;

  always_comb begin
    line_cls        = content_seen ? CLS_SOURCE : CLS_BLANK;
    block_open_next = block_open;
    if (bl != '0) begin
      if (block_open) begin
        if (end_seen) begin
          line_cls        = CLS_BLOCK_END;
          block_open_next = 1'b0;
        end else begin
          line_cls = CLS_BLOCK_INSIDE;
        end
      end else if (start_hit) begin
        line_cls        = CLS_BLOCK_START;
        block_open_next = !end_seen;
      end
    end else if ((sl != '0) && single_hit) begin
      line_cls = CLS_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_open <= 1'b0;
    end else if (line_take) begin
      block_open <= block_open_next;
    end
  end

  // result register with a one-entry skid buffer behind it
  res_t res_new;
  res_t res_out;
  res_t res_skid;
  logic skid_valid;
  logic result_take;

  assign res_new     = '{cls: line_cls, in_block: block_open_next};
  assign result_take = result_valid && !result_stall;
  assign item_stall  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        skid_valid <= 1'b0;
      end
    end else if (line_take) begin
      if (result_valid && !result_take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_take) begin
        res_out <= res_skid;
      end
    end else if (line_take) begin
      if (result_valid && !result_take) begin
        res_skid <= res_new;
      end else begin
        res_out <= res_new;
      end
    end
  end

  assign line_class = res_out.cls;
  assign in_block   = res_out.in_block;

  // A line end taken with the result register full and stalled fills the skid.
  `CLC_ASSERT(a_skid_fill, (line_take && result_valid && result_stall) |=> item_stall)
  // After every line end, a result is valid in the next cycle.
  `CLC_ASSERT(a_result_follows, line_take |=> result_valid)
  // The block flag moves only at a line end.
  `CLC_ASSERT(a_block_hold, !line_take |=> $stable(block_open))
  // A line inside a block leaves the block open; an end line closes it.
  `CLC_ASSERT(a_class_flag, result_valid |-> ((line_class != CLS_BLOCK_INSIDE || in_block) && (line_class != CLS_BLOCK_END || !in_block)))

endmodule

### sv/ccl_cell.sv
// One window cell: holds a recent byte and checks it against the end token.
module ccl_cell #(
  parameter int TOKEN_BYTES = 8,
  parameter int CELL_INDEX  = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ccl_pkg::ctl_t             ctl,
  input  logic [ccl_pkg::BYTE_W-1:0] byte_in,
  input  logic                      valid_in,
  input  logic [ccl_pkg::LEN_W-1:0] end_len,
  input  logic [ccl_pkg::TOK_W-1:0] end_token,
  output logic [ccl_pkg::BYTE_W-1:0] held_byte,
  output logic                      held_valid,
  output logic                      miss
);
  import ccl_pkg::*;

  logic             mismatch;
  logic [LEN_W-1:0] pos;

  // Compare the incoming byte with every token byte that lands on this cell.
  // Token byte i sits end_len-1-i cells behind the newest byte.
  always_comb begin
    mismatch = 1'b0;
    pos      = '0;
    for (int i = 0; i < TOKEN_BYTES; i++) begin
      pos = end_len - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < end_len) && (pos == LEN_W'(CELL_INDEX)) &&
          (byte_in != end_token[BYTE_W*i +: BYTE_W])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign miss = (LEN_W'(CELL_INDEX) < end_len) && (!valid_in || mismatch);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held_valid <= 1'b0;
    end else if (ctl.shift) begin
      held_valid <= valid_in;
    end
  end

endmodule

### sv/ccl_prefix.sv
// Prefix matcher: tracks whether the trimmed line opens with a token.
module ccl_prefix (
  input  logic                       clk,
  input  logic                       rst,
  input  ccl_pkg::ctl_t              ctl,
  input  logic [ccl_pkg::BYTE_W-1:0] char_code,
  input  logic [ccl_pkg::CNT_W-1:0]  count,
  input  logic [ccl_pkg::LEN_W-1:0]  len,
  input  logic [ccl_pkg::TOK_W-1:0]  token,
  output logic                       hit
);
  import ccl_pkg::*;

  logic prefix_ok;
  logic prefix_ok_next;

  always_comb begin
    prefix_ok_next = prefix_ok;
    if (ctl.clear) begin
      prefix_ok_next = 1'b1;
    end else if (ctl.shift && (count < CNT_W'(len)) &&
                 (char_code != tok_byte(token, count[IDX_W-1:0]))) begin
      prefix_ok_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_ok <= 1'b1;
    end else begin
      prefix_ok <= prefix_ok_next;
    end
  end

  assign hit = prefix_ok && (count >= CNT_W'(len));

endmodule

### tb/sv/tb_comment_line_classifier.sv
// Self-checking testbench for the comment line classifier: directed table, then random lines.
module tb_comment_line_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import ccl_pkg::*;

  localparam int          CLK_HALF        = 6;      // 12 ns period
  localparam int          WIN             = 8;      // token window depth of the block
  localparam int          ITEMS_PER_PHASE = 205;    // minimum transfers per register setting
  localparam int          HOLD_CYCLES     = 400;    // long result hold-off
  localparam int          SETTLE_CYCLES   = 4;      // settle time after the last owed result
  localparam longint      CYCLE_LIMIT     = 400000;
  // Reset values of the token registers: "//", "/*" and "*/", byte 0 lowest.
  localparam logic [63:0] DEF_SINGLE_TOK  = 64'd12079;
  localparam logic [63:0] DEF_START_TOK   = 64'd10799;
  localparam logic [63:0] DEF_END_TOK     = 64'd12074;
  localparam logic [3:0]  DEF_LEN         = 4'd2;

  // Register settings walked in order; the last one runs without idling.
  typedef enum int {
    PH_DEFAULT, PH_SINGLE_ONLY, PH_ALL_ONES, PH_NO_RULES, PH_RANDOM,
    PH_LONG_TOKENS, PH_ZERO_TOKENS, PH_RESTORE, PH_COUNT
  } phase_t;

  // Shapes of generated lines.
  typedef enum int {
    LN_START, LN_START_END, LN_SINGLE, LN_END, LN_BLANK, LN_TEXT, LN_TOKEN_MIX, LN_NOISE
  } line_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       le;
    logic       typed;   // expectation below is fixed; otherwise ask the predictor
    res_t       want;
  } text_row_t;

  // Directed lines under the reset setting ("//", "/*", "*/").
  localparam int DIR_ROWS = 26;
  localparam text_row_t DIRECTED [DIR_ROWS] = '{
    // bare line end straight after reset
    '{8'h41, 1'b1, 1'b1, '{CLS_BLANK, 1'b0}},
    // whitespace-only line: every skipped code, then the line end
    '{8'h20, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h09, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h0A, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h0B, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h0C, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h0D, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{CLS_BLANK, 1'b0}},
    // a line shorter than the start token is plain source
    '{8'h2F, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{CLS_SOURCE, 1'b0}},
    // open a block
    '{8'h2F, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h2A, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, '{CLS_BLOCK_START, 1'b1}},
    // an empty line inside an open block is never blank
    '{8'h20, 1'b1, 1'b1, '{CLS_BLOCK_INSIDE, 1'b1}},
    // close the block with the end token after other text
    '{8'h78, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h2A, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h2F, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h01, 1'b1, 1'b1, '{CLS_BLOCK_END, 1'b0}},
    // start and end on the same line: leave it to the predictor
    '{8'h2F, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h2A, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h2A, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h2F, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h80, 1'b1, 1'b0, '{CLS_BLANK, 1'b0}},
    // byte extremes as line content
    '{8'hFF, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{CLS_BLANK, 1'b0}},
    '{8'hFE, 1'b1, 1'b1, '{CLS_SOURCE, 1'b0}}
  };

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [7:0]  char_code;
  logic        line_end;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  line_class;
  logic        in_block;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  comment_line_classifier #(
    .TOKEN_BYTES (WIN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .char_code    (char_code),
    .line_end     (line_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .line_class   (line_class),
    .in_block     (in_block),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor copy of the registers.
  logic [63:0] single_tok, start_tok, end_tok;
  logic [3:0]  single_len_r, start_len_r, end_len_r;
  // Predictor copy of the line state.
  logic        blk_open, content_seen, single_ok, start_ok, end_hit;
  int unsigned content_cnt, fill;
  logic [7:0]  recent [WIN];       // [0] holds the newest byte

  res_t        class_q [$];        // line classes still owed by the block
  logic [7:0]  line_text [$];      // bytes of the line being built

  // Run bookkeeping.
  bit          valid_up;           // item_valid was last driven high
  bit          quiet;              // no idling on either side
  bit          hold_req;           // ask the receiver for one long hold-off
  int unsigned items_used, bytes_kept, lines_sent, stall_cycles, fail_count;
  int unsigned class_seen [6];
  longint      cycles;

  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Lengths above the window depth behave as the full window.
  function automatic int unsigned cap_len(input logic [3:0] len);
    return (len > 4'(WIN)) ? WIN : len;
  endfunction

  function automatic void clear_line_state();
    content_seen = 1'b0;
    content_cnt  = 0;
    single_ok    = 1'b1;
    start_ok     = 1'b1;
    end_hit      = 1'b0;
    fill         = 0;
    foreach (recent[i]) recent[i] = 8'h00;
  endfunction

  // Advance the line state by one transfer. used is low for skipped leading
  // whitespace; has_res is high on a line end, with the class in res.
  task automatic classify_step(input logic [7:0] ch, input logic le, output logic used,
                               output logic has_res, output res_t res);
    int unsigned sl, bl, el, i;
    logic        hit;
    class_t      cls;
    sl      = cap_len(single_len_r);
    bl      = cap_len(start_len_r);
    el      = cap_len(end_len_r);
    used    = 1'b1;
    has_res = 1'b0;
    res     = '0;
    if (!le) begin
      if (!content_seen && (ch inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D})) begin
        used = 1'b0;
        return;
      end
      content_seen = 1'b1;
      // Prefix checks run over the first bytes of the trimmed line only.
      if (content_cnt < sl && ch != single_tok[8*content_cnt +: 8])
        single_ok = 1'b0;
      if (content_cnt < bl && ch != start_tok[8*content_cnt +: 8])
        start_ok = 1'b0;
      if (content_cnt < WIN)
        content_cnt++;
      for (i = WIN - 1; i > 0; i--)
        recent[i] = recent[i-1];
      recent[0] = ch;
      if (fill < WIN)
        fill++;
      // End token may sit anywhere: compare the last el bytes, oldest first.
      if (el > 0 && fill >= el) begin
        hit = 1'b1;
        for (i = 0; i < el; i++)
          if (recent[el-1-i] != end_tok[8*i +: 8])
            hit = 1'b0;
        if (hit)
          end_hit = 1'b1;
      end
    end else begin
      if (bl > 0) begin
        // Block rules replace the single-line rule entirely.
        if (blk_open) begin
          if (end_hit) begin
            blk_open = 1'b0;
            cls      = CLS_BLOCK_END;
          end else begin
            cls = CLS_BLOCK_INSIDE;
          end
        end else if (start_ok && content_cnt >= bl) begin
          if (!end_hit)
            blk_open = 1'b1;
          cls = CLS_BLOCK_START;
        end else begin
          cls = content_seen ? CLS_SOURCE : CLS_BLANK;
        end
      end else if (sl > 0 && single_ok && content_cnt >= sl) begin
        cls = CLS_SINGLE;
      end else begin
        cls = content_seen ? CLS_SOURCE : CLS_BLANK;
      end
      res.cls      = cls;
      res.in_block = blk_open;   // held over even while block rules are off
      has_res      = 1'b1;
      clear_line_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one transfer, hold it until taken, then predict. An idle burst may
  // follow; otherwise valid stays high for the next transfer.
  task automatic send_item(input logic [7:0] ch, input logic le, input logic use_typed,
                           input res_t typed_res);
    logic used, has_res;
    res_t got;
    item_valid <= 1'b1;
    char_code  <= ch;
    line_end   <= le;
    valid_up    = 1'b1;
    do @(posedge clk); while (item_stall);
    classify_step(ch, le, used, has_res, got);
    items_used++;
    if (used)
      bytes_kept++;
    if (has_res) begin
      class_q = {class_q, (use_typed ? typed_res : got)};
      lines_sent++;
    end
    if (!quiet && $urandom_range(0, 9) == 0) begin
      item_valid <= 1'b0;
      valid_up    = 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Write one register; the write lands at the next edge.
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SINGLE_TOKEN: single_tok   = val;
      REG_SINGLE_LEN:   single_len_r = val[3:0];
      REG_START_TOKEN:  start_tok    = val;
      REG_START_LEN:    start_len_r  = val[3:0];
      REG_END_TOKEN:    end_tok      = val;
      REG_END_LEN:      end_len_r    = val[3:0];
      default: ;
    endcase
  endtask

  // Stop offering, wait for every owed class, then let the block settle.
  task automatic drain_results();
    if (valid_up) begin
      item_valid <= 1'b0;
      valid_up    = 1'b0;
    end
    while (class_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Line generation
  // ---------------------------------------------------------------------------

  // One of the six whitespace codes skipped at the start of a line.
  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Append a token at its effective length (a random one when that is zero), now and then cut short.
  function automatic void push_token(input logic [63:0] tok, input logic [3:0] len);
    int unsigned k, i;
    k = cap_len(len);
    if (k == 0)
      k = $urandom_range(1, WIN);
    if ($urandom_range(0, 4) == 0)
      k = $urandom_range(0, k - 1);
    for (i = 0; i < k; i++)
      line_text = {line_text, tok[8*i +: 8]};
  endfunction

  // Body byte: token bytes are common so that partial and shifted matches occur.
  function automatic logic [7:0] body_byte(input bit token_heavy);
    int unsigned idx;
    idx = $urandom_range(0, WIN - 1);
    case ($urandom_range(0, token_heavy ? 2 : 7))
      0:       return start_tok[8*idx +: 8];
      1:       return end_tok[8*idx +: 8];
      2:       return single_tok[8*idx +: 8];
      3:       return pick_space();
      4:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  // Build one line of the given shape and send it, line end included.
  task automatic send_line(input line_kind_t kind);
    int unsigned n, i;
    line_text.delete();
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++)
      line_text = {line_text, pick_space()};
    case (kind)
      LN_START, LN_START_END: push_token(start_tok, start_len_r);
      LN_SINGLE:              push_token(single_tok, single_len_r);
      default: ;
    endcase
    if (kind != LN_BLANK) begin
      n = (kind == LN_NOISE) ? $urandom_range(1, 14) : $urandom_range(0, 6);
      for (i = 0; i < n; i++)
        line_text = {line_text, (kind == LN_NOISE ? 8'($urandom_range(0, 255))
                                                  : body_byte(kind == LN_TOKEN_MIX))};
    end
    if (kind inside {LN_START_END, LN_END}) begin
      push_token(end_tok, end_len_r);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++)
        line_text = {line_text, body_byte(1'b0)};
    end
    foreach (line_text[i])
      send_item(line_text[i], 1'b0, 1'b0, '0);
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pacing and checking
  // ---------------------------------------------------------------------------

  // Stall the result channel in random bursts; take one long hold-off on
  // request so that the block fills and stalls its input.
  initial begin : result_pacing
    int unsigned n;
    bit          hold_taken;
    hold_taken   = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest owed class.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst) begin
      if (item_valid && item_stall)
        stall_cycles++;
      if (result_valid && !result_stall) begin
        if (class_q.size() == 0) begin
          $error("unexpected result: line_class %0d in_block %0d", line_class, in_block);
          fail_count++;
        end else begin
          want = class_q.pop_front();
          if (line_class !== want.cls) begin
            $error("line_class mismatch: expected %0d, got %0d", want.cls, line_class);
            fail_count++;
          end
          if (in_block !== want.in_block) begin
            $error("in_block mismatch: expected %0d, got %0d", want.in_block, in_block);
            fail_count++;
          end
          class_seen[int'(want.cls)]++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results owed", cycles, class_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    phase_t      ph;
    line_kind_t  kind;
    int          p;
    int unsigned start_count;
    logic [63:0] t_single, t_start, t_end, hi;
    logic [3:0]  l_single, l_start, l_end;

    // Known values on every input from time zero.
    rst        = 1'b1;
    item_valid = 1'b0;
    char_code  = 8'h00;
    line_end   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_SINGLE_TOKEN;
    cfg_data   = '0;
    valid_up   = 1'b0;
    quiet      = 1'b0;
    hold_req   = 1'b0;

    // Predictor starts from the reset setting with no block open.
    single_tok   = DEF_SINGLE_TOK;
    start_tok    = DEF_START_TOK;
    end_tok      = DEF_END_TOK;
    single_len_r = DEF_LEN;
    start_len_r  = DEF_LEN;
    end_len_r    = DEF_LEN;
    blk_open     = 1'b0;
    clear_line_state();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: fixed expectations where typed, predictor elsewhere.
    foreach (DIRECTED[r])
      send_item(DIRECTED[r].ch, DIRECTED[r].le, DIRECTED[r].typed, DIRECTED[r].want);

    for (p = 0; p < PH_COUNT; p++) begin
      ph = phase_t'(p);
      if (ph != PH_DEFAULT) begin
        drain_results();
        quiet    = (ph == PH_RESTORE);
        hi       = {$urandom, $urandom};   // junk above the length field
        t_single = {$urandom, $urandom};
        t_start  = {$urandom, $urandom};
        t_end    = {$urandom, $urandom};
        case (ph)
          PH_SINGLE_ONLY: begin
            // Block rules off: the open block must carry through untouched.
            l_single = 4'($urandom_range(1, WIN));
            l_start  = 4'd0;
            l_end    = 4'($urandom_range(0, WIN));
          end
          PH_ALL_ONES: begin
            t_single = '1;
            t_start  = '1;
            t_end    = '1;
            l_single = 4'hF;
            l_start  = 4'hF;
            l_end    = 4'hF;
          end
          PH_NO_RULES: begin
            t_single = '0;
            t_start  = '0;
            t_end    = '0;
            l_single = 4'd0;
            l_start  = 4'd0;
            l_end    = 4'd0;
          end
          PH_LONG_TOKENS: begin
            l_single = 4'(WIN);
            l_start  = 4'(WIN + 1);
            l_end    = 4'(WIN);
          end
          PH_ZERO_TOKENS: begin
            t_single = '0;
            t_start  = '0;
            l_single = 4'($urandom_range(1, WIN));
            l_start  = 4'($urandom_range(1, 3));
            l_end    = 4'd1;
          end
          PH_RESTORE: begin
            t_single = DEF_SINGLE_TOK;
            t_start  = DEF_START_TOK;
            t_end    = DEF_END_TOK;
            l_single = DEF_LEN;
            l_start  = DEF_LEN;
            l_end    = DEF_LEN;
          end
          default: begin
            l_single = 4'($urandom_range(0, 15));
            l_start  = 4'($urandom_range(0, 15));
            l_end    = 4'($urandom_range(0, 15));
          end
        endcase
        write_reg(REG_SINGLE_TOKEN, t_single);
        write_reg(REG_SINGLE_LEN,   {hi[59:0], l_single});
        write_reg(REG_START_TOKEN,  t_start);
        write_reg(REG_START_LEN,    {hi[63:4], l_start});
        write_reg(REG_END_TOKEN,    t_end);
        write_reg(REG_END_LEN,      {~hi[59:0], l_end});
        cfg_we <= 1'b0;
      end

      start_count = items_used;
      while (items_used - start_count < ITEMS_PER_PHASE) begin
        // One long hold-off early on, while the sender keeps offering.
        if (ph == PH_DEFAULT && items_used - start_count >= 40)
          hold_req = 1'b1;
        case ($urandom_range(0, 15))
          0, 1, 2:  kind = LN_START;
          3, 4:     kind = LN_START_END;
          5, 6, 7:  kind = LN_SINGLE;
          8, 9:     kind = LN_END;
          10:       kind = LN_BLANK;
          11, 12:   kind = LN_TEXT;
          13:       kind = LN_TOKEN_MIX;
          default:  kind = LN_NOISE;
        endcase
        send_line(kind);
      end

      // Leave a block open so the next setting, with block rules off, shows it held.
      if (ph == PH_DEFAULT) begin
        send_item(8'h2F, 1'b0, 1'b0, '0);
        send_item(8'h2A, 1'b0, 1'b0, '0);
        send_item(8'h00, 1'b1, 1'b0, '0);
      end
    end

    drain_results();

    $display("covered %0d lines, %0d transfers (%0d kept bytes), %0d settings, %0d stalls",
             lines_sent, items_used, bytes_kept, PH_COUNT, stall_cycles);
    $display("classes seen blank/source/single/inside/end/start: %0d %0d %0d %0d %0d %0d",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4],
             class_seen[5]);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
